[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: command and error
// codes, and the command group from the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

  localparam int unsigned CmdWidth = 3;
  localparam int unsigned ErrWidth = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4
  } dq_cmd_e;

  typedef enum logic [ErrWidth-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } dq_err_e;

  // controller -> datapath
  typedef struct packed {
    logic load;  // take a command word and update pointers and store
    logic read;  // read front and back entries
  } dq_ctrl_t;

endpackage

`default_nettype wire

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue in a ring store, one result word per command.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries command words (push back, push front, pop
//   front, pop back, clear); every accepted word yields exactly one result
//   word on the master stream with the front and back elements, a not-empty
//   flag, the occupancy and an error code (pop on empty, push on full).
//   Failed pops and pushes leave the queue untouched; clear empties it at once.
//   A command updates the pointers and writes the store when it is
//   accepted; the front and back entries are then read into registers,
//   and the result is valid after that registered read. No new command
//   is taken while one is in flight; the next command is taken in the
//   cycle the pending result is taken, bounded by the store read.
//   While the sink holds m_axis_tready low the result stays put and no new
//   command is taken. Reset empties the queue and needs no clearing pass;
//   store contents are only passed on from inside the occupied span.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ELEMENT_WIDTH = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // slave tdata: cmd, push_value
  input  wire logic [((3 + ELEMENT_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // master tdata: front_value, back_value, not_empty, occupancy, error_code
  output logic [((2 * ELEMENT_WIDTH + $clog2(DEPTH + 1) + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready
);

  import dq_pkg::*;

  localparam int unsigned CW       = $clog2(DEPTH + 1);
  localparam int unsigned OutRaw   = 2 * ELEMENT_WIDTH + 1 + CW + ErrWidth;
  localparam int unsigned OutWidth = ((OutRaw + 7) / 8) * 8;

  dq_ctrl_t                  ctrl;
  logic [ELEMENT_WIDTH-1:0]  front_value;
  logic [ELEMENT_WIDTH-1:0]  back_value;
  logic                      not_empty;
  logic [CW-1:0]             occupancy;
  logic [ErrWidth-1:0]       error_code;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .ctrl_o      (ctrl)
  );

  dq_datapath #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cmd_i         (s_axis_tdata[CmdWidth-1:0]),
    .push_value_i  (s_axis_tdata[CmdWidth +: ELEMENT_WIDTH]),
    .front_value_o (front_value),
    .back_value_o  (back_value),
    .not_empty_o   (not_empty),
    .occupancy_o   (occupancy),
    .error_code_o  (error_code)
  );

  assign m_axis_tdata = OutWidth'({error_code, occupancy, not_empty, back_value, front_value});

endmodule

`default_nettype wire

[rtl/dq_ram.sv]
// ----------------------------------------------------------------------------
// dq_ram
// Generic RAM: one write port, two read ports sharing one enable,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

[rtl/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for the queue: takes a command word, schedules the store read,
// then holds the result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output dq_pkg::dq_ctrl_t     ctrl_o
);

  import dq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SEND = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   load;

  // a new word may enter in the same cycle the pending result leaves
  assign in_ready_o  = (state_q == S_IDLE) || ((state_q == S_SEND) && out_ready_i);
  assign load        = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_SEND);

  assign ctrl_o.load = load;
  assign ctrl_o.read = (state_q == S_READ);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (load) state_d = S_READ;
      end
      S_READ: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_ready_i) state_d = load ? S_READ : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/dq_datapath.sv]
// ----------------------------------------------------------------------------
// dq_datapath
// Head pointer, element count and error register of the queue, with the
// ring store and the front/back lookup that forms each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_datapath #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned ELEMENT_WIDTH = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dq_pkg::dq_ctrl_t           ctrl_i,
  input  wire logic [dq_pkg::CmdWidth-1:0] cmd_i,
  input  wire logic [ELEMENT_WIDTH-1:0]   push_value_i,
  output logic      [ELEMENT_WIDTH-1:0]   front_value_o,
  output logic      [ELEMENT_WIDTH-1:0]   back_value_o,
  output logic                            not_empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] occupancy_o,
  output logic      [dq_pkg::ErrWidth-1:0] error_code_o
);

  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DepthS = SW'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  dq_err_e       err_q, err_d;

  logic          full, empty;
  logic          we;
  logic [AW-1:0] waddr;
  logic [SW-1:0] tail_sum, back_sum;
  logic [AW-1:0] tail_idx, back_idx, head_dec, head_inc;
  logic [ELEMENT_WIDTH-1:0] rd_front, rd_back;

  assign full  = (count_q == DepthC);
  assign empty = (count_q == '0);

  // sums stay below twice the depth while the queue is not empty, one conditional subtract wraps them
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail_idx = (tail_sum >= DepthS) ? AW'(tail_sum - DepthS) : AW'(tail_sum);
  assign back_sum = SW'(head_q) + SW'(count_q) - SW'(1);
  assign back_idx = (back_sum >= DepthS) ? AW'(back_sum - DepthS) : AW'(back_sum);
  assign head_dec = (head_q == '0) ? LastIdx : head_q - AW'(1);
  assign head_inc = (head_q == LastIdx) ? '0 : head_q + AW'(1);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    err_d   = ERR_OK;
    we      = 1'b0;
    waddr   = tail_idx;
    case (dq_cmd_e'(cmd_i))
      CMD_PUSH_BACK: begin
        if (full) begin
          err_d = ERR_FULL;
        end else begin
          we      = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          err_d = ERR_FULL;
        end else begin
          we      = 1'b1;
          waddr   = head_dec;
          head_d  = head_dec;
          count_d = count_q + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          err_d = ERR_EMPTY;
        end else begin
          head_d  = head_inc;
          count_d = count_q - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          err_d = ERR_EMPTY;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      CMD_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      err_q   <= ERR_OK;
    end else if (ctrl_i.load) begin
      head_q  <= head_d;
      count_q <= count_d;
      err_q   <= err_d;
    end
  end

  dq_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ctrl_i.load && we),
    .waddr_i   (waddr),
    .wdata_i   (push_value_i),
    .re_i      (ctrl_i.read),
    .raddr_a_i (head_q),
    .raddr_b_i (back_idx),
    .rdata_a_o (rd_front),
    .rdata_b_o (rd_back)
  );

  assign not_empty_o   = !empty;
  assign front_value_o = empty ? '0 : rd_front;
  assign back_value_o  = empty ? '0 : rd_back;
  assign occupancy_o   = count_q;
  assign error_code_o  = err_q;

endmodule

`default_nettype wire

[verif/double_ended_queue_test.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the double-ended queue. A short table of directed
// commands walks empty and full corners, every command and spare codes 5 and 7,
// then random fill, drain and mixed bursts run under three idling patterns
// and one long sink stall. Every result word is checked field by field,
// against the row's expected word where a table row gives one, else against a behavioral deque held in the bench.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TableRows  = 25;
  localparam int unsigned BurstLen   = 40;

  // spare command codes, decoded as no operation
  localparam logic [CmdWidth-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CmdWidth-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CmdWidth-1:0] CMD_SPARE_7 = 3'd7;

  // burst flavors of the random part
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_e;

  // same layout as m_axis_tdata, lowest field last
  typedef struct packed {
    dq_err_e    err;
    logic [4:0] occupancy;
    logic       not_empty;
    logic [7:0] back_value;
    logic [7:0] front_value;
  } dq_view_t;

  typedef struct {
    logic [CmdWidth-1:0] cmd;
    logic [7:0]          value;
    bit                  typed;
    dq_view_t            want;
  } cmd_row_t;

  localparam dq_view_t EMPTY_VIEW     = '{ERR_OK,    5'd0, 1'b0, 8'h00, 8'h00};
  localparam dq_view_t EMPTY_POP_VIEW = '{ERR_EMPTY, 5'd0, 1'b0, 8'h00, 8'h00};

  cmd_row_t cmd_table [TableRows] = '{
    '{CMD_POP_FRONT,  8'h00, 1'b1, EMPTY_POP_VIEW},
    '{CMD_POP_BACK,   8'hFF, 1'b1, EMPTY_POP_VIEW},
    '{CMD_PUSH_BACK,  8'h00, 1'b1, '{ERR_OK, 5'd1, 1'b1, 8'h00, 8'h00}},
    '{CMD_PUSH_FRONT, 8'hFF, 1'b1, '{ERR_OK, 5'd2, 1'b1, 8'h00, 8'hFF}},
    '{CMD_SPARE_7,    8'hFF, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_BACK,  8'h01, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_FRONT, 8'h02, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_BACK,  8'h04, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_FRONT, 8'h08, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_BACK,  8'h10, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_FRONT, 8'h20, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_BACK,  8'h40, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_FRONT, 8'h80, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_BACK,  8'h7F, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_FRONT, 8'hBF, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_BACK,  8'hDF, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_FRONT, 8'hEF, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_BACK,  8'hF7, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_FRONT, 8'hFB, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_BACK,  8'h5A, 1'b0, EMPTY_VIEW},
    '{CMD_PUSH_FRONT, 8'hA5, 1'b0, EMPTY_VIEW},
    '{CMD_POP_BACK,   8'h00, 1'b0, EMPTY_VIEW},
    '{CMD_POP_FRONT,  8'h00, 1'b0, EMPTY_VIEW},
    '{CMD_SPARE_5,    8'h33, 1'b0, EMPTY_VIEW},
    '{CMD_CLEAR,      8'hCC, 1'b1, EMPTY_VIEW}
  };

  logic        clk_i;
  logic        rst_ni;
  logic [15:0] s_axis_tdata;   // cmd, push_value, zero fill
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] m_axis_tdata;   // front_value, back_value, not_empty, occupancy, error_code
  logic        m_axis_tvalid;
  logic        m_axis_tready;

  double_ended_queue u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  // bench copy of the deque
  logic [7:0] ring_copy [Depth];
  logic [3:0] head_copy;
  logic [4:0] count_copy;

  cmd_row_t   offered_rows [$];
  dq_view_t   pending_views [$];
  int         mismatch_count;
  int         tx_idle_pct;
  int         rx_idle_pct;
  bit         hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // applies one command to the bench deque and returns the view after it
  function automatic dq_view_t apply_command(logic [CmdWidth-1:0] cmd, logic [7:0] value);
    dq_view_t view;
    view = EMPTY_VIEW;
    case (cmd)
      CMD_PUSH_BACK: begin
        if (count_copy >= Depth) begin
          view.err = ERR_FULL;
        end else begin
          ring_copy[head_copy + count_copy[3:0]] = value;
          count_copy++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (count_copy >= Depth) begin
          view.err = ERR_FULL;
        end else begin
          head_copy = head_copy - 4'd1;
          ring_copy[head_copy] = value;
          count_copy++;
        end
      end
      CMD_POP_FRONT: begin
        if (count_copy == 0) begin
          view.err = ERR_EMPTY;
        end else begin
          head_copy = head_copy + 4'd1;
          count_copy--;
        end
      end
      CMD_POP_BACK: begin
        if (count_copy == 0) begin
          view.err = ERR_EMPTY;
        end else begin
          count_copy--;
        end
      end
      CMD_CLEAR: begin
        head_copy  = '0;
        count_copy = '0;
      end
      default: ;
    endcase
    if (count_copy != 0) begin
      view.front_value = ring_copy[head_copy];
      // a count of sixteen wraps to zero here, which still lands on head - 1
      view.back_value  = ring_copy[head_copy + count_copy[3:0] - 4'd1];
      view.not_empty   = 1'b1;
    end
    view.occupancy = count_copy;
    return view;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // output first, so a word accepted in the same cycle never meets its own result
  always @(posedge clk_i) begin
    dq_view_t got;
    dq_view_t want;
    dq_view_t predicted;
    cmd_row_t row;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = dq_view_t'(m_axis_tdata);
        if (pending_views.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %h",
                   $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = pending_views.pop_front();
          report_field("front_value", want.front_value, got.front_value);
          report_field("back_value",  want.back_value,  got.back_value);
          report_field("not_empty",   want.not_empty,   got.not_empty);
          report_field("occupancy",   want.occupancy,   got.occupancy);
          report_field("error_code",  want.err,         got.err);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        row = offered_rows.pop_front();
        predicted = apply_command(row.cmd, row.value);
        pending_views.push_back(row.typed ? row.want : predicted);
      end
    end
  end

  // sink side: random stalls, plus one long hold when asked
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_word(cmd_row_t row);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    offered_rows.push_back(row);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, row.value, row.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // bursts lean toward filling, draining or neither so both full and empty recur
  task automatic send_random(int unsigned n);
    cmd_row_t row;
    mix_e     mix;
    int       roll;
    int       push_pct;
    mix = MIX_EVEN;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % BurstLen == 0) begin
        mix = mix_e'($urandom_range(2));
      end
      push_pct = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 25 : 50;
      roll = $urandom_range(99);
      row.typed = 1'b0;
      row.want  = EMPTY_VIEW;
      row.value = 8'($urandom_range(255));
      if (roll < 2) begin
        row.cmd = CMD_CLEAR;
      end else if (roll < 5) begin
        row.cmd = CmdWidth'($urandom_range(CMD_SPARE_7, CMD_SPARE_5));
      end else if ($urandom_range(99) < push_pct) begin
        row.cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      end else begin
        row.cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end
      send_word(row);
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    mismatch_count = 0;
    hold_req       = 1'b0;
    head_copy      = '0;
    count_copy     = '0;
    tx_idle_pct    = 21;
    rx_idle_pct    = 47;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned r = 0; r < TableRows; r++) begin
      send_word(cmd_table[r]);
    end
    send_random(560);

    tx_idle_pct = 47;
    rx_idle_pct = 21;
    hold_req    = 1'b1;
    send_random(560);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random(560);
    s_axis_tvalid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk_i);
    drain_cycles = 20;
    repeat (drain_cycles) @(posedge clk_i);

    if (mismatch_count == 0 && pending_views.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
